// ===== hdl/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg
// types and constants shared by the vector normalize pipeline
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int unsigned CoordBits    = 16;
  localparam int unsigned UnitFracBits = 14;
  localparam int unsigned UnitBits     = UnitFracBits + 2;
  localparam int unsigned MagBits      = CoordBits;
  localparam int unsigned SumBits      = 2 * CoordBits + 2;
  localparam int unsigned RootSteps    = SumBits / 2;
  localparam int unsigned DivBits      = CoordBits + UnitFracBits;
  localparam int unsigned QuotBits     = UnitFracBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] vec_x;
    logic signed [CoordBits-1:0] vec_y;
    logic signed [CoordBits-1:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic        [CoordBits-1:0] length;
    logic signed [UnitBits-1:0]  unit_x;
    logic signed [UnitBits-1:0]  unit_y;
    logic signed [UnitBits-1:0]  unit_z;
    logic                        is_zero;
  } out_item_t;

  // state carried through the divider stages for one component
  typedef struct packed {
    logic [DivBits-1:0]  num;
    logic [MagBits:0]    rem;
    logic [QuotBits-1:0] quot;
    logic                neg;
  } div_lane_t;

endpackage

// ===== hdl/v3n_div_stage.sv =====
// ----------------------------------------------------------------------------
// v3n_div_stage
// one restoring division step for one lane, combinational
// ----------------------------------------------------------------------------
module v3n_div_stage (
  input  v3n_pkg::div_lane_t      lane_i,
  input  logic [v3n_pkg::MagBits-1:0] den_i,
  output v3n_pkg::div_lane_t      lane_o
);
  logic [v3n_pkg::MagBits+1:0] trial;
  logic [v3n_pkg::MagBits+1:0] shifted;

  always_comb begin
    shifted = {lane_i.rem, lane_i.num[v3n_pkg::DivBits-1]};
    trial   = shifted - {2'b00, den_i};
    lane_o  = lane_i;
    lane_o.num = {lane_i.num[v3n_pkg::DivBits-2:0], 1'b0};
    if (!trial[v3n_pkg::MagBits+1]) begin
      lane_o.rem  = trial[v3n_pkg::MagBits:0];
      lane_o.quot = {lane_i.quot[v3n_pkg::QuotBits-2:0], 1'b1};
    end else begin
      lane_o.rem  = shifted[v3n_pkg::MagBits:0];
      lane_o.quot = {lane_i.quot[v3n_pkg::QuotBits-2:0], 1'b0};
    end
  end
endmodule

// ===== hdl/vector3_normalize_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// pipeline: magnitudes, squares, sum, root stages, divider stages, output register
// throughput: one item per cycle, busy is always low
// square root: one digit per stage, division: one quotient bit per stage
// reset clears the valid bits only, payload registers are not reset
// receiver cannot stall, each result is shown for one cycle on done_o
// ----------------------------------------------------------------------------
module vector3_normalize_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  v3n_pkg::in_item_t   item_i,
  output logic                done_o,
  output v3n_pkg::out_item_t  item_o
);
  localparam int unsigned CB = v3n_pkg::CoordBits;
  localparam int unsigned SB = v3n_pkg::SumBits;
  localparam int unsigned RS = v3n_pkg::RootSteps;
  localparam int unsigned DB = v3n_pkg::DivBits;
  localparam int unsigned MB = v3n_pkg::MagBits;
  localparam int unsigned UB = v3n_pkg::UnitBits;
  localparam int unsigned NS = RS + 1;

  // no stall anywhere: the pipe always advances
  assign busy = 1'b0;

  // ---- stage 1: magnitudes and signs
  logic            v1_q;
  logic [CB-1:0]   ax_q, ay_q, az_q;
  logic [2:0]      n1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    ax_q <= item_i.vec_x[CB-1] ? CB'(-item_i.vec_x) : CB'(item_i.vec_x);
    ay_q <= item_i.vec_y[CB-1] ? CB'(-item_i.vec_y) : CB'(item_i.vec_y);
    az_q <= item_i.vec_z[CB-1] ? CB'(-item_i.vec_z) : CB'(item_i.vec_z);
    n1_q <= {item_i.vec_x[CB-1], item_i.vec_y[CB-1], item_i.vec_z[CB-1]};
  end

  // ---- stage 2: squares, one multiplier each
  logic              v2_q;
  logic [2*CB-1:0]   sx_q, sy_q, sz_q;
  logic [CB-1:0]     bx2_q, by2_q, bz2_q;
  logic [2:0]        n2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    sx_q <= ax_q * ax_q;
    sy_q <= ay_q * ay_q;
    sz_q <= az_q * az_q;
    bx2_q <= ax_q; by2_q <= ay_q; bz2_q <= az_q;
    n2_q <= n1_q;
  end

  // ---- stage 3 onward: sum, then root digits per stage
  logic [NS-1:0]   rv_q;
  logic [SB-1:0]   rn_q  [RS+1];
  logic [SB-1:0]   rr_q  [RS+1];
  logic [CB-1:0]   rbx_q [RS+1];
  logic [CB-1:0]   rby_q [RS+1];
  logic [CB-1:0]   rbz_q [RS+1];
  logic [2:0]      rng_q [RS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= '0;
    else         rv_q <= {rv_q[NS-2:0], v2_q};
  end

  always_ff @(posedge clk_i) begin
    rn_q[0]  <= SB'(sx_q) + SB'(sy_q) + SB'(sz_q);
    rr_q[0]  <= '0;
    rbx_q[0] <= bx2_q; rby_q[0] <= by2_q; rbz_q[0] <= bz2_q;
    rng_q[0] <= n2_q;
  end

  for (genvar s = 0; s < RS; s++) begin : g_root
    logic [SB-1:0] bitv, cand;
    always_comb begin
      bitv = SB'(1) << (2 * (RS - 1 - s));
      cand = rr_q[s] + bitv;
    end
    always_ff @(posedge clk_i) begin
      if (rn_q[s] >= cand) begin
        rn_q[s+1] <= rn_q[s] - cand;
        rr_q[s+1] <= (rr_q[s] >> 1) + bitv;
      end else begin
        rn_q[s+1] <= rn_q[s];
        rr_q[s+1] <= rr_q[s] >> 1;
      end
      rbx_q[s+1] <= rbx_q[s]; rby_q[s+1] <= rby_q[s]; rbz_q[s+1] <= rbz_q[s];
      rng_q[s+1] <= rng_q[s];
    end
  end

  // ---- divider: one quotient bit per stage for each lane
  logic [MB-1:0]          root_len;
  assign root_len = rr_q[RS][MB-1:0];

  v3n_pkg::div_lane_t     dl_q  [3][DB+1];
  logic [MB-1:0]          dd_q  [DB+1];
  logic [DB:0]            dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else         dv_q <= {dv_q[DB-1:0], rv_q[RS]};
  end

  always_ff @(posedge clk_i) begin
    dd_q[0] <= root_len;
    dl_q[0][0] <= '{num: {rbx_q[RS], {v3n_pkg::UnitFracBits{1'b0}}}, rem: '0,
                    quot: '0, neg: rng_q[RS][2]};
    dl_q[1][0] <= '{num: {rby_q[RS], {v3n_pkg::UnitFracBits{1'b0}}}, rem: '0,
                    quot: '0, neg: rng_q[RS][1]};
    dl_q[2][0] <= '{num: {rbz_q[RS], {v3n_pkg::UnitFracBits{1'b0}}}, rem: '0,
                    quot: '0, neg: rng_q[RS][0]};
  end

  for (genvar d = 0; d < DB; d++) begin : g_div
    v3n_pkg::div_lane_t nxt [3];
    for (genvar l = 0; l < 3; l++) begin : g_lane
      v3n_div_stage u_step (
        .lane_i (dl_q[l][d]),
        .den_i  (dd_q[d]),
        .lane_o (nxt[l])
      );
      always_ff @(posedge clk_i) dl_q[l][d+1] <= nxt[l];
    end
    always_ff @(posedge clk_i) dd_q[d+1] <= dd_q[d];
  end

  // ---- output: sign and zero handling
  logic          zero;
  logic [UB-1:0] ux, uy, uz;
  assign zero = (dd_q[DB] == '0);

  function automatic logic [UB-1:0] signed_unit(v3n_pkg::div_lane_t l);
    logic [UB-1:0] m;
    m = UB'(l.quot);
    return l.neg ? UB'(-m) : m;
  endfunction

  assign ux = signed_unit(dl_q[0][DB]);
  assign uy = signed_unit(dl_q[1][DB]);
  assign uz = signed_unit(dl_q[2][DB]);

  logic                done_q;
  v3n_pkg::out_item_t  res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_q[DB];
  end
  always_ff @(posedge clk_i) begin
    res_q.length  <= dd_q[DB];
    res_q.unit_x  <= zero ? '0 : ux;
    res_q.unit_y  <= zero ? '0 : uy;
    res_q.unit_z  <= zero ? '0 : uz;
    res_q.is_zero <= zero;
  end

  assign done_o = done_q;
  assign item_o = res_q;
endmodule

// ===== hdl/v3n_checker.sv =====
// ----------------------------------------------------------------------------
// v3n_checker
// port-level assertions for the normalize unit
// ----------------------------------------------------------------------------
module v3n_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               done_o,
  input v3n_pkg::out_item_t item_o
);
  // never stalls
  a_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  // zero flag matches length
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (item_o.is_zero == (item_o.length == '0)))
    else $error("zero flag mismatch");
  // zero vector gives zero components
  a_zunit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && item_o.is_zero) |->
      (item_o.unit_x == '0 && item_o.unit_y == '0 && item_o.unit_z == '0))
    else $error("zero vector components");
  // unit x component bounded by one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (item_o.unit_x <= 16384 && item_o.unit_x >= -16384))
    else $error("unit x out of range");
endmodule

bind vector3_normalize_unit v3n_checker u_v3n_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .busy   (busy),
  .done_o (done_o),
  .item_o (item_o)
);
